>>> rtl/wdm_pkg.sv
// shared types, codes and helpers for the wildcard domain matcher
package wdm_pkg;

  localparam int CHAR_W = 8;
  localparam int SIZE_W = 6;

  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_MATCH = 1'b1;

  // control from the top level to the pattern store, one per accepted beat
  typedef struct packed {
    logic              clear;
    logic              take;
    logic [CHAR_W-1:0] ch;
  } wdm_ctl_t;

  typedef struct packed {
    logic              overflow;
    logic [SIZE_W-1:0] size;
  } wdm_stat_t;

  typedef struct packed {
    logic              kind;
    logic              matched;
    logic              overflow;
    logic [SIZE_W-1:0] size;
  } wdm_res_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    begin
      r = c;
      if (c >= CH_UP_A && c <= CH_UP_Z) r = c + CASE_OFS;
      return r;
    end
  endfunction

endpackage

>>> rtl/wdm_in_if.sv
// input channel: pattern and domain characters
interface wdm_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [wdm_pkg::CHAR_W-1:0] char_code;
  logic                     no_char;
  logic                     final_char;

  modport source (output valid, op, char_code, no_char, final_char, input ready);
  modport sink   (input valid, op, char_code, no_char, final_char, output ready);
endinterface

>>> rtl/wdm_out_if.sv
// result channel: load acknowledgements and match verdicts
interface wdm_out_if;
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic                     matched;
  logic                     pattern_overflow;
  logic [wdm_pkg::SIZE_W-1:0] pattern_size;

  modport source (output valid, result_kind, matched, pattern_overflow, pattern_size,
                  input ready);
  modport sink   (input valid, result_kind, matched, pattern_overflow, pattern_size,
                  output ready);
endinterface

>>> rtl/wildcard_domain_match_core.sv
// top level of the case-insensitive wildcard domain matcher
// Loads a glob pattern (op 0) one character per beat, then matches domain
// characters (op 1) against it, both folded to lower case, with a trailing
// dot on a final beat dropped; '*' matches any run and '?' one character.
// For each accepted beat the set of reachable pattern positions is updated
// by a parallel compare against all stored characters and a single carry
// chain across MAX_PATTERN+1 bits for the star closure, then registered.
// One result comes per final beat, registered in the output buffer. A
// two-entry output buffer keeps the input open while a result waits. No
// initialization pass is needed after reset.
module wildcard_domain_match_core #(
  parameter int MAX_PATTERN = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  wdm_in_if.sink        in_ch,
  wdm_out_if.source     out_ch
);

  localparam int W = MAX_PATTERN + 1;

  logic                        load_r, load_nxt;
  logic                        dom_r, dom_nxt;
  logic [W-1:0]                reach_r, reach_nxt;
  logic [W-1:0]                base, adv, reach_calc, close_mask;
  logic [MAX_PATTERN-1:0]      star_v, qmark_v, eq_v, step;
  logic [W-1:0]                start_set;
  logic [wdm_pkg::CHAR_W-1:0]  ch;
  logic                        take, acc, ld_acc, md_acc, hit, push, pop;
  wdm_pkg::wdm_ctl_t           ctl;
  wdm_pkg::wdm_stat_t          stat_cur, stat_nxt;
  wdm_pkg::wdm_res_t           res, head_r, skid_r;
  logic                        head_vld_r, skid_vld_r;

  function automatic logic [W-1:0] star_close(input logic [W-1:0] set,
                                               input logic [W-1:0] m);
    logic [W-1:0] a;
    begin
      // carries ripple a set bit through each run of stars
      a = set & m;
      return set | ((a + m) ^ m);
    end
  endfunction

  assign ch     = wdm_pkg::fold_case(in_ch.char_code);
  assign take   = !in_ch.no_char && !(in_ch.final_char && ch == wdm_pkg::CH_DOT);
  assign acc    = in_ch.valid && in_ch.ready;
  assign ld_acc = acc && (in_ch.op == wdm_pkg::OP_LOAD);
  assign md_acc = acc && (in_ch.op == wdm_pkg::OP_MATCH);

  assign ctl.clear = ld_acc && !load_r;
  assign ctl.take  = ld_acc && take;
  assign ctl.ch    = ch;

  wdm_pattern #(.MAX_PATTERN(MAX_PATTERN)) u_pattern (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat_cur  (stat_cur),
    .stat_nxt  (stat_nxt),
    .star_v    (star_v),
    .qmark_v   (qmark_v),
    .eq_v      (eq_v),
    .start_set (start_set)
  );

  always_comb begin
    base       = dom_r ? reach_r : start_set;
    close_mask = {1'b0, star_v};
    step       = base[MAX_PATTERN-1:0] & ~star_v & (qmark_v | eq_v);
    adv        = {1'b0, base[MAX_PATTERN-1:0] & star_v} | {step, 1'b0};
    reach_calc = take ? star_close(adv, close_mask) : base;
    hit        = 1'b0;
    for (int i = 0; i < W; i++) begin
      if (stat_cur.size == wdm_pkg::SIZE_W'(i)) hit = reach_calc[i];
    end
  end

  always_comb begin
    load_nxt  = load_r;
    dom_nxt   = dom_r;
    reach_nxt = reach_r;
    if (ld_acc) begin
      load_nxt = !in_ch.final_char;
      if (!load_r) dom_nxt = 1'b0;
    end else if (md_acc) begin
      load_nxt  = 1'b0;
      dom_nxt   = !in_ch.final_char;
      reach_nxt = reach_calc;
    end
  end

  always_comb begin
    res.kind     = in_ch.op;
    res.matched  = (in_ch.op == wdm_pkg::OP_MATCH) ? hit : 1'b0;
    res.overflow = stat_nxt.overflow;
    res.size     = stat_nxt.size;
  end

  assign push        = acc && in_ch.final_char;
  assign pop         = head_vld_r && out_ch.ready;
  assign in_ch.ready = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r     <= 1'b0;
      dom_r      <= 1'b0;
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      load_r <= load_nxt;
      dom_r  <= dom_nxt;
      if (!head_vld_r || pop) begin
        if (skid_vld_r) begin
          head_vld_r <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          head_vld_r <= push;
        end
      end else if (push) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    reach_r <= reach_nxt;
    if (!head_vld_r || pop) begin
      head_r <= skid_vld_r ? skid_r : res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid            = head_vld_r;
  assign out_ch.result_kind      = head_r.kind;
  assign out_ch.matched          = head_r.matched;
  assign out_ch.pattern_overflow = head_r.overflow;
  assign out_ch.pattern_size     = head_r.size;

endmodule

>>> rtl/wdm_pattern.sv
// pattern store: characters, wildcard masks, length, overflow and start set
module wdm_pattern #(
  parameter int MAX_PATTERN = 63
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wdm_pkg::wdm_ctl_t      ctl,
  output wdm_pkg::wdm_stat_t     stat_cur,
  output wdm_pkg::wdm_stat_t     stat_nxt,
  output logic [MAX_PATTERN-1:0] star_v,
  output logic [MAX_PATTERN-1:0] qmark_v,
  output logic [MAX_PATTERN-1:0] eq_v,
  output logic [MAX_PATTERN:0]   start_set
);

  localparam int W = MAX_PATTERN + 1;

  logic [wdm_pkg::CHAR_W-1:0] store_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     star_r;
  logic [MAX_PATTERN-1:0]     qmark_r;
  logic [wdm_pkg::SIZE_W-1:0] len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [W-1:0]               start_r, start_nxt, start_base;
  logic [wdm_pkg::SIZE_W-1:0] wr_pos;
  logic                       wr_en;
  logic [MAX_PATTERN-1:0]     valid_pos;

  assign wr_pos = ctl.clear ? '0 : len_r;
  assign wr_en  = ctl.take && (wr_pos < wdm_pkg::SIZE_W'(MAX_PATTERN));

  always_comb begin
    len_nxt    = ctl.clear ? '0 : len_r;
    ovf_nxt    = ctl.clear ? 1'b0 : ovf_r;
    start_base = ctl.clear ? W'(1) : start_r;
    start_nxt  = start_base;
    if (ctl.take) begin
      if (wr_en) len_nxt = wr_pos + 1'b1;
      else       ovf_nxt = 1'b1;
    end
    // appending a star extends the closure of position zero by one step
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (wr_en && wr_pos == wdm_pkg::SIZE_W'(i) && start_base[i] &&
          ctl.ch == wdm_pkg::CH_STAR)
        start_nxt[i+1] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      ovf_r   <= 1'b0;
      start_r <= W'(1);
    end else begin
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (wr_en && wr_pos == wdm_pkg::SIZE_W'(i)) begin
        store_r[i] <= ctl.ch;
        star_r[i]  <= (ctl.ch == wdm_pkg::CH_STAR);
        qmark_r[i] <= (ctl.ch == wdm_pkg::CH_QMARK);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      valid_pos[i] = wdm_pkg::SIZE_W'(i) < len_r;
      star_v[i]    = valid_pos[i] && star_r[i];
      qmark_v[i]   = valid_pos[i] && qmark_r[i];
      eq_v[i]      = valid_pos[i] && (store_r[i] == ctl.ch);
    end
  end

  assign stat_cur.overflow = ovf_r;
  assign stat_cur.size     = len_r;
  assign stat_nxt.overflow = ovf_nxt;
  assign stat_nxt.size     = len_nxt;
  assign start_set         = start_r;

endmodule

>>> rtl/wdm_checker.sv
// port-level checks for the wildcard domain matcher, bound to the top level
module wdm_checker #(
  parameter int MAX_PATTERN = 63
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_result_kind,
  input logic                       out_matched,
  input logic                       out_pattern_overflow,
  input logic [wdm_pkg::SIZE_W-1:0] out_pattern_size
);

  // a stalled result beat keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
    $stable(out_matched) && $stable(out_pattern_overflow) && $stable(out_pattern_size))
    else $error("result beat changed while stalled");

  // input closes only when both output entries are full
  a_ready_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_load_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == wdm_pkg::KIND_LOAD |-> !out_matched)
    else $error("load result reports a match");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pattern_size <= wdm_pkg::SIZE_W'(MAX_PATTERN))
    else $error("pattern size beyond capacity");

  // overflow only happens once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pattern_overflow |-> out_pattern_size == wdm_pkg::SIZE_W'(MAX_PATTERN))
    else $error("overflow with store not full");

endmodule

bind wildcard_domain_match_core wdm_checker #(.MAX_PATTERN(MAX_PATTERN)) u_wdm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_result_kind      (out_ch.result_kind),
  .out_matched          (out_ch.matched),
  .out_pattern_overflow (out_ch.pattern_overflow),
  .out_pattern_size     (out_ch.pattern_size)
);
